// ----- hw/rtl/ring_fifo_with_newest_sum_macros.svh -----
// Assertion macros shared by the ring FIFO RTL.
`ifndef RING_FIFO_WITH_NEWEST_SUM_MACROS_SVH
`define RING_FIFO_WITH_NEWEST_SUM_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define RF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ring fifo check failed");
// Next-cycle implication, disabled while reset is asserted.
`define RF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ring fifo check failed");
`else
`define RF_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define RF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/rf_pkg.sv -----
// Shared types and constants for the ring FIFO with newest-word sum.
`default_nettype none

package rf_pkg;

    // Default sizes
    localparam int MAX_DEPTH_DEF  = 16;
    localparam int WORD_BITS_DEF  = 32;

    // Field widths fixed by the interface
    localparam int OP_W     = 3;
    localparam int CNT_W    = 5;
    localparam int STATUS_W = 2;

    // Depth register value after reset
    localparam logic [CNT_W-1:0] DEPTH_RESET = 5'd16;

    // Entries in the request queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Request op codes as they arrive on the port
    typedef enum logic [OP_W-1:0] {
        OP_PUSH     = 3'd0,
        OP_POP      = 3'd1,
        OP_PEEK_OLD = 3'd2,
        OP_PEEK_NEW = 3'd3,
        OP_SUM      = 3'd4,
        OP_STATUS   = 3'd5
    } t_op;

    // Classified request kind handed to the back end
    typedef enum logic [2:0] {
        K_PUSH,
        K_POP,
        K_PEEK_OLD,
        K_PEEK_NEW,
        K_SUM,
        K_STATUS
    } t_kind;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_OVER  = 2'd3
    } t_status;

    // Control part of one queued request
    typedef struct packed {
        t_kind             kind;
        logic [CNT_W-1:0]  count;
    } t_cmd;

endpackage

`default_nettype wire

// ----- hw/rtl/ring_fifo_with_newest_sum.sv -----
// Top level of the ring FIFO with newest-word sum.
//
// Requests are taken when start is high and busy is low; a two-entry queue
// sits between the request port and the execution unit, so busy rises only
// when two requests wait. Every request gives one result, shown for exactly
// one cycle with o_result_valid; the receiver cannot stall it. The result of
// a push, status or error request is registered as the request is taken;
// pop and peek pass through the registered memory read and S_READ, a sum
// through S_SUM. Only pop, peek and sum can take the execution unit out of
// idle, so push and status run at one request per cycle; the single read
// port of the ring memory sets the sum time, one word per cycle. The depth
// register is written through the cfg channel, which is ready only while no
// request is queued or executing; a write empties the FIFO (stored words are
// kept but no longer counted).
`default_nettype none

module ring_fifo_with_newest_sum #(
    parameter int MAX_DEPTH = rf_pkg::MAX_DEPTH_DEF,
    parameter int WORD_BITS = rf_pkg::WORD_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [rf_pkg::OP_W-1:0]             i_op,
    input  wire logic signed [WORD_BITS-1:0]         i_push_value,
    input  wire logic [rf_pkg::CNT_W-1:0]            i_sum_count,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [rf_pkg::CNT_W-1:0]            i_cfg_data,
    output logic                                     o_result_valid,
    output logic [rf_pkg::STATUS_W-1:0]              o_status,
    output logic signed [WORD_BITS-1:0]              o_read_data,
    output logic [rf_pkg::CNT_W-1:0]                 o_occupancy,
    output logic                                     o_is_empty,
    output logic                                     o_is_full
);

    logic                   w_front_empty;
    logic                   w_back_idle;
    logic                   w_cmd_valid;
    rf_pkg::t_cmd           w_cmd;
    logic [WORD_BITS-1:0]   w_cmd_value;
    logic                   w_cmd_pop;
    logic                   w_cfg_we;

    // Config is taken only with nothing in flight
    assign o_cfg_ready = w_front_empty && w_back_idle;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    rf_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_op         (i_op),
        .i_push_value (i_push_value),
        .i_sum_count  (i_sum_count),
        .o_empty      (w_front_empty),
        .o_cmd_valid  (w_cmd_valid),
        .o_cmd        (w_cmd),
        .o_cmd_value  (w_cmd_value),
        .i_cmd_pop    (w_cmd_pop)
    );

    rf_back #(
        .MAX_DEPTH (MAX_DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (w_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_cmd_valid    (w_cmd_valid),
        .i_cmd          (w_cmd),
        .i_cmd_value    (w_cmd_value),
        .o_cmd_pop      (w_cmd_pop),
        .o_idle         (w_back_idle),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_read_data    (o_read_data),
        .o_occupancy    (o_occupancy),
        .o_is_empty     (o_is_empty),
        .o_is_full      (o_is_full)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/rf_front.sv -----
// Front end: takes requests, classifies the op and queues them for the back end.
`default_nettype none
`include "ring_fifo_with_newest_sum_macros.svh"

module rf_front #(
    parameter int WORD_BITS = rf_pkg::WORD_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    output logic                                     o_busy,
    input  wire logic [rf_pkg::OP_W-1:0]             i_op,
    input  wire logic signed [WORD_BITS-1:0]         i_push_value,
    input  wire logic [rf_pkg::CNT_W-1:0]            i_sum_count,
    output logic                                     o_empty,
    output logic                                     o_cmd_valid,
    output rf_pkg::t_cmd                             o_cmd,
    output logic [WORD_BITS-1:0]                     o_cmd_value,
    input  wire logic                                i_cmd_pop
);

    localparam int QD    = rf_pkg::QUEUE_DEPTH;
    localparam int QP_W  = $clog2(QD);
    localparam int QC_W  = $clog2(QD + 1);

    rf_pkg::t_cmd          r_q_cmd [QD];
    logic [WORD_BITS-1:0]  r_q_val [QD];
    logic [QP_W-1:0]       r_wr_ptr, n_wr_ptr;
    logic [QP_W-1:0]       r_rd_ptr, n_rd_ptr;
    logic [QC_W-1:0]       r_q_cnt, n_q_cnt;
    logic                  w_accept;
    rf_pkg::t_cmd          w_cmd;

    assign o_busy      = (r_q_cnt == QC_W'(QD));
    assign w_accept    = i_start && !o_busy;
    assign o_empty     = (r_q_cnt == '0);
    assign o_cmd_valid = !o_empty;
    assign o_cmd       = r_q_cmd[r_rd_ptr];
    assign o_cmd_value = r_q_val[r_rd_ptr];

    // Classify the op; unused codes act as a status query
    always_comb begin
        w_cmd.count = i_sum_count;
        case (i_op)
            rf_pkg::OP_PUSH:     w_cmd.kind = rf_pkg::K_PUSH;
            rf_pkg::OP_POP:      w_cmd.kind = rf_pkg::K_POP;
            rf_pkg::OP_PEEK_OLD: w_cmd.kind = rf_pkg::K_PEEK_OLD;
            rf_pkg::OP_PEEK_NEW: w_cmd.kind = rf_pkg::K_PEEK_NEW;
            rf_pkg::OP_SUM:      w_cmd.kind = rf_pkg::K_SUM;
            default:             w_cmd.kind = rf_pkg::K_STATUS;
        endcase
    end

    // Queue pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_q_cnt  = r_q_cnt;
        if (w_accept) begin
            n_wr_ptr = (r_wr_ptr == QP_W'(QD - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_cmd_pop) begin
            n_rd_ptr = (r_rd_ptr == QP_W'(QD - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_accept && !i_cmd_pop) begin
            n_q_cnt = r_q_cnt + 1'b1;
        end else if (!w_accept && i_cmd_pop) begin
            n_q_cnt = r_q_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_q_cnt  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_q_cnt  <= n_q_cnt;
        end
    end

    // Queue payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_q_cmd[r_wr_ptr] <= w_cmd;
            r_q_val[r_wr_ptr] <= i_push_value;
        end
    end

    // Checks
    `RF_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, w_accept, r_q_cnt != '0)
    `RF_ASSERT_NOW(a_pop_has_entry, i_clk, i_rst_n, i_cmd_pop, o_cmd_valid)
    `RF_ASSERT_NOW(a_fill_in_range, i_clk, i_rst_n, 1'b1, r_q_cnt <= QC_W'(QD))

endmodule

`default_nettype wire

// ----- hw/rtl/rf_back.sv -----
// Back end: ring storage, pointers, depth register and request execution.
`default_nettype none
`include "ring_fifo_with_newest_sum_macros.svh"

module rf_back #(
    parameter int MAX_DEPTH = rf_pkg::MAX_DEPTH_DEF,
    parameter int WORD_BITS = rf_pkg::WORD_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [rf_pkg::CNT_W-1:0]            i_cfg_data,
    input  wire logic                                i_cmd_valid,
    input  wire rf_pkg::t_cmd                        i_cmd,
    input  wire logic [WORD_BITS-1:0]                i_cmd_value,
    output logic                                     o_cmd_pop,
    output logic                                     o_idle,
    output logic                                     o_result_valid,
    output logic [rf_pkg::STATUS_W-1:0]              o_status,
    output logic signed [WORD_BITS-1:0]              o_read_data,
    output logic [rf_pkg::CNT_W-1:0]                 o_occupancy,
    output logic                                     o_is_empty,
    output logic                                     o_is_full
);

    localparam int CW      = rf_pkg::CNT_W;
    localparam int PTR_W   = $clog2(MAX_DEPTH);
    localparam int CMP_W   = ((PTR_W > CW) ? PTR_W : CW) + 1;
    localparam int CNT_MAX = (1 << CW) - 1;
    localparam logic [CW-1:0] DEPTH_CAP =
        (MAX_DEPTH > CNT_MAX) ? CW'(CNT_MAX) : CW'(MAX_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_SUM  = 3'b100
    } t_state;

    // Pointer step forward with wrap at the effective depth
    function automatic logic [PTR_W-1:0] f_fwd(input logic [PTR_W-1:0] i,
                                              input logic [CW-1:0] d);
        logic [CMP_W-1:0] nx;
        nx = CMP_W'(i) + 1'b1;
        return (nx >= CMP_W'(d)) ? '0 : nx[PTR_W-1:0];
    endfunction

    // Pointer step back with wrap to the last used slot
    function automatic logic [PTR_W-1:0] f_back(input logic [PTR_W-1:0] i,
                                               input logic [CW-1:0] d);
        logic [CW-1:0] last;
        last = d - 1'b1;
        return ((i == '0) || (CMP_W'(i) >= CMP_W'(d))) ? PTR_W'(last) : i - 1'b1;
    endfunction

    logic [WORD_BITS-1:0]   r_mem [MAX_DEPTH];
    logic [WORD_BITS-1:0]   r_rdata;

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_depth, n_depth;
    logic [PTR_W-1:0]       r_head, n_head;
    logic [PTR_W-1:0]       r_tail, n_tail;
    logic [CW-1:0]          r_count, n_count;
    logic [PTR_W-1:0]       r_idx, n_idx;
    logic [CW-1:0]          r_remaining, n_remaining;
    logic [WORD_BITS-1:0]   r_acc, n_acc;

    logic                   r_out_valid, n_out_valid;
    rf_pkg::t_status        r_out_status, n_out_status;
    logic [WORD_BITS-1:0]   r_out_data, n_out_data;
    logic [CW-1:0]          r_out_occ;
    logic                   r_out_empty;
    logic                   r_out_full;

    logic [CW-1:0]          w_eff;
    logic                   w_mem_we;
    logic                   w_rd_en;
    logic [PTR_W-1:0]       w_rd_addr;

    // Depth register clamped to 1..DEPTH_CAP (MAX_DEPTH, but at most 31)
    always_comb begin
        if (r_depth == '0) begin
            w_eff = CW'(1);
        end else if (r_depth > DEPTH_CAP) begin
            w_eff = DEPTH_CAP;
        end else begin
            w_eff = r_depth;
        end
    end

    assign o_idle = (r_state == S_IDLE);

    // Request execution
    always_comb begin
        n_state      = r_state;
        n_depth      = r_depth;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_idx        = r_idx;
        n_remaining  = r_remaining;
        n_acc        = r_acc;
        n_out_valid  = 1'b0;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        o_cmd_pop    = 1'b0;
        w_mem_we     = 1'b0;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_head;

        case (r_state)
            S_IDLE: begin
                if (i_cfg_we) begin
                    n_depth = i_cfg_data;
                    n_head  = '0;
                    n_tail  = '0;
                    n_count = '0;
                end else if (i_cmd_valid) begin
                    o_cmd_pop    = 1'b1;
                    n_out_status = rf_pkg::ST_OK;
                    n_out_data   = '0;
                    case (i_cmd.kind)
                        rf_pkg::K_PUSH: begin
                            n_out_valid = 1'b1;
                            if (r_count >= w_eff) begin
                                n_out_status = rf_pkg::ST_FULL;
                            end else begin
                                w_mem_we = 1'b1;
                                n_tail   = f_fwd(r_tail, w_eff);
                                n_count  = r_count + 1'b1;
                            end
                        end
                        rf_pkg::K_POP, rf_pkg::K_PEEK_OLD: begin
                            if (r_count == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_status = rf_pkg::ST_EMPTY;
                            end else begin
                                w_rd_en   = 1'b1;
                                w_rd_addr = r_head;
                                n_state   = S_READ;
                                if (i_cmd.kind == rf_pkg::K_POP) begin
                                    n_head  = f_fwd(r_head, w_eff);
                                    n_count = r_count - 1'b1;
                                end
                            end
                        end
                        rf_pkg::K_PEEK_NEW: begin
                            if (r_count == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_status = rf_pkg::ST_EMPTY;
                            end else begin
                                w_rd_en   = 1'b1;
                                w_rd_addr = f_back(r_tail, w_eff);
                                n_state   = S_READ;
                            end
                        end
                        rf_pkg::K_SUM: begin
                            if (r_count == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_status = rf_pkg::ST_EMPTY;
                            end else if (i_cmd.count > r_count) begin
                                n_out_valid  = 1'b1;
                                n_out_status = rf_pkg::ST_OVER;
                            end else if (i_cmd.count == '0) begin
                                n_out_valid = 1'b1;
                            end else begin
                                // first read at the newest slot, walk backward
                                w_rd_en     = 1'b1;
                                w_rd_addr   = f_back(r_tail, w_eff);
                                n_idx       = w_rd_addr;
                                n_remaining = i_cmd.count - 1'b1;
                                n_acc       = '0;
                                n_state     = S_SUM;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_out_valid  = 1'b1;
                n_out_status = rf_pkg::ST_OK;
                n_out_data   = r_rdata;
                n_state      = S_IDLE;
            end
            S_SUM: begin
                if (r_remaining == '0) begin
                    n_out_valid  = 1'b1;
                    n_out_status = rf_pkg::ST_OK;
                    n_out_data   = r_acc + r_rdata;
                    n_state      = S_IDLE;
                end else begin
                    n_acc       = r_acc + r_rdata;
                    w_rd_en     = 1'b1;
                    w_rd_addr   = f_back(r_idx, w_eff);
                    n_idx       = w_rd_addr;
                    n_remaining = r_remaining - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= rf_pkg::DEPTH_RESET;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_remaining <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_remaining <= n_remaining;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath and result registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_acc        <= n_acc;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
        r_out_occ    <= n_count;
        r_out_empty  <= (n_count == '0);
        r_out_full   <= (n_count == w_eff);
    end

    // Ring storage: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_tail] <= i_cmd_value;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_status       = r_out_status;
    assign o_read_data    = r_out_data;
    assign o_occupancy    = r_out_occ;
    assign o_is_empty     = r_out_empty;
    assign o_is_full      = r_out_full;

    // Checks
    `RF_ASSERT_NOW(a_count_in_depth, i_clk, i_rst_n, 1'b1, r_count <= w_eff)
    `RF_ASSERT_NEXT(a_pop_drops_one, i_clk, i_rst_n, (r_state == S_IDLE) && !i_cfg_we && i_cmd_valid && (i_cmd.kind == rf_pkg::K_POP) && (r_count != '0), r_count == ($past(r_count) - 1'b1))
    `RF_ASSERT_NEXT(a_sum_ends, i_clk, i_rst_n, (r_state == S_SUM) && (r_remaining == '0), r_out_valid && (r_state == S_IDLE))

endmodule

`default_nettype wire

// ----- tb/ring_fifo_with_newest_sum_tb.sv -----
// Self-checking testbench for the ring FIFO with newest-word sum.
`timescale 1ns / 1ps

module ring_fifo_with_newest_sum_tb;

    // Unused op codes, answered like a status query
    localparam logic [2:0] OP_UNUSED_LO = 3'd6;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    localparam logic [31:0] WORD_MIN = 32'h8000_0000;
    localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam int          RING_SLOTS = 16;
    localparam int          SHOWN_MAX = 10;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] value;
        logic [4:0]  count;
    } t_fifo_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] data;
        logic [4:0]  occupancy;
        logic        is_empty;
        logic        is_full;
    } t_fifo_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_op = '0;
    logic [31:0] i_push_value = '0;
    logic [4:0]  i_sum_count = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_data = '0;
    logic        o_result_valid;
    logic [1:0]  o_status;
    logic [31:0] o_read_data;
    logic [4:0]  o_occupancy;
    logic        o_is_empty;
    logic        o_is_full;

    // Request and expectation queues
    t_fifo_req    pending_requests[$];
    t_fifo_result expected_results[$];
    t_fifo_req    next_req;
    t_fifo_result seen_result;
    t_fifo_result want_result;

    int unsigned requests_issued = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_count = 0;
    bit          burst_mode = 1'b0;

    // Predicted FIFO state
    logic [31:0] ring_mem[RING_SLOTS];
    int unsigned head_ptr = 0;
    int unsigned tail_ptr = 0;
    int unsigned held_words = 0;
    logic [4:0]  depth_reg = rf_pkg::DEPTH_RESET;

    // Occupancy as the request stream will leave it, for shaping stimulus
    int unsigned plan_held = 0;
    int unsigned plan_depth = RING_SLOTS;

    ring_fifo_with_newest_sum dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_push_value   (i_push_value),
        .i_sum_count    (i_sum_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_read_data    (o_read_data),
        .o_occupancy    (o_occupancy),
        .o_is_empty     (o_is_empty),
        .o_is_full      (o_is_full)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Register value clamped to 1..RING_SLOTS
    function automatic int unsigned clamp_depth(input logic [4:0] v);
        if (v < 1) return 1;
        if (v > RING_SLOTS) return RING_SLOTS;
        return 32'(v);
    endfunction

    function automatic int unsigned ring_next(input int unsigned i, input int unsigned d);
        return (i + 1 >= d) ? 0 : i + 1;
    endfunction

    function automatic int unsigned ring_prev(input int unsigned i, input int unsigned d);
        return (i == 0 || i >= d) ? d - 1 : i - 1;
    endfunction

    // Applies one request to the predicted state and returns its result
    function automatic t_fifo_result predict_fifo_result(input logic [2:0] op,
                                                         input logic [31:0] value,
                                                         input logic [4:0] count);
        t_fifo_result r;
        int unsigned  d;
        int unsigned  idx;
        int unsigned  k;
        r = '0;
        r.status = rf_pkg::ST_OK;
        d = clamp_depth(depth_reg);
        case (op)
            rf_pkg::OP_PUSH: begin
                if (held_words >= d) begin
                    r.status = rf_pkg::ST_FULL;
                end else begin
                    ring_mem[tail_ptr % RING_SLOTS] = value;
                    tail_ptr = ring_next(tail_ptr, d);
                    held_words++;
                end
            end
            rf_pkg::OP_POP, rf_pkg::OP_PEEK_OLD: begin
                if (held_words == 0) begin
                    r.status = rf_pkg::ST_EMPTY;
                end else begin
                    r.data = ring_mem[head_ptr % RING_SLOTS];
                    if (op == rf_pkg::OP_POP) begin
                        head_ptr = ring_next(head_ptr, d);
                        held_words--;
                    end
                end
            end
            rf_pkg::OP_PEEK_NEW: begin
                if (held_words == 0) r.status = rf_pkg::ST_EMPTY;
                else r.data = ring_mem[ring_prev(tail_ptr, d) % RING_SLOTS];
            end
            rf_pkg::OP_SUM: begin
                if (held_words == 0) begin
                    r.status = rf_pkg::ST_EMPTY;
                end else if (count > held_words) begin
                    r.status = rf_pkg::ST_OVER;
                end else begin
                    // newest first, wrapping at the word width
                    idx = ring_prev(tail_ptr, d);
                    for (k = 0; k < count; k++) begin
                        r.data = r.data + ring_mem[idx % RING_SLOTS];
                        idx = ring_prev(idx, d);
                    end
                end
            end
            default: ;
        endcase
        r.occupancy = held_words[4:0];
        r.is_empty = (held_words == 0);
        r.is_full = (held_words == d);
        return r;
    endfunction

    task automatic add_req(input logic [2:0] op, input logic [31:0] value,
                           input logic [4:0] count);
        pending_requests.push_back('{op, value, count});
        requests_issued++;
        if (op == rf_pkg::OP_PUSH && plan_held < plan_depth) plan_held++;
        else if (op == rf_pkg::OP_POP && plan_held > 0) plan_held--;
    endtask

    // Depth write once every result is in; empties the FIFO
    task automatic write_depth(input logic [4:0] v);
        do @(posedge i_clk); while (results_checked != requests_issued);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        depth_reg = v;
        head_ptr = 0;
        tail_ptr = 0;
        held_words = 0;
        plan_depth = clamp_depth(v);
        plan_held = 0;
    endtask

    // Random requests; push_pct steers the fill level
    task automatic queue_random(input int n, input int unsigned push_pct);
        int          i;
        int unsigned pick;
        logic [2:0]  op;
        logic [31:0] value;
        logic [4:0]  count;
        for (i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < push_pct) begin
                op = rf_pkg::OP_PUSH;
            end else begin
                pick = $urandom_range(99);
                if (pick < 35) op = rf_pkg::OP_POP;
                else if (pick < 45) op = rf_pkg::OP_PEEK_OLD;
                else if (pick < 55) op = rf_pkg::OP_PEEK_NEW;
                else if (pick < 85) op = rf_pkg::OP_SUM;
                else if (pick < 95) op = rf_pkg::OP_STATUS;
                else if (pick < 98) op = OP_UNUSED_LO;
                else op = OP_UNUSED_HI;
            end
            case ($urandom_range(7))
                0: value = WORD_MIN;
                1: value = WORD_MAX;
                2: value = '1;
                default: value = $urandom;
            endcase
            // mostly legal sum lengths, some past the fill level
            if ($urandom_range(9) < 7) count = 5'($urandom_range(plan_held));
            else count = 5'($urandom_range(31));
            add_req(op, value, count);
        end
    endtask

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_results.push_back(
                    predict_fifo_result(i_op, i_push_value, i_sum_count));
            end
            if (!start || !busy) begin
                if (pending_requests.size() != 0 &&
                    (burst_mode || $urandom_range(99) >= 34)) begin
                    next_req = pending_requests.pop_front();
                    start <= 1'b1;
                    i_op <= next_req.op;
                    i_push_value <= next_req.value;
                    i_sum_count <= next_req.count;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= SHOWN_MAX) $display("%0t: %s", $time, msg);
    endtask

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            seen_result.status = o_status;
            seen_result.data = o_read_data;
            seen_result.occupancy = o_occupancy;
            seen_result.is_empty = o_is_empty;
            seen_result.is_full = o_is_full;
            if (expected_results.size() == 0) begin
                flag_mismatch($sformatf("result with no request pending: st=%0d data=%h",
                                        o_status, o_read_data));
            end else begin
                want_result = expected_results.pop_front();
                results_checked++;
                if (seen_result !== want_result) begin
                    flag_mismatch($sformatf(
                        "exp st=%0d d=%h occ=%0d e=%0b f=%0b, got st=%0d d=%h occ=%0d e=%0b f=%0b",
                        want_result.status, want_result.data, want_result.occupancy,
                        want_result.is_empty, want_result.is_full,
                        seen_result.status, seen_result.data, seen_result.occupancy,
                        seen_result.is_empty, seen_result.is_full));
                end
            end
        end
    end

    // Stimulus
    initial begin
        logic [4:0] phase_depth[10];
        int         p;
        phase_depth = '{5'd16, 5'd0, 5'd2, 5'd31, 5'd5, 5'd17, 5'd1, 5'd9, 5'd16, 5'd3};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty FIFO: every read kind reports empty
        add_req(rf_pkg::OP_POP, '0, 5'd0);
        add_req(rf_pkg::OP_PEEK_OLD, '0, 5'd0);
        add_req(rf_pkg::OP_PEEK_NEW, '0, 5'd0);
        add_req(rf_pkg::OP_SUM, '0, 5'd3);
        add_req(rf_pkg::OP_STATUS, '0, 5'd0);
        // Extreme words, then peeks and sums over them, unused codes and a pop
        add_req(rf_pkg::OP_PUSH, WORD_MIN, 5'd0);
        add_req(rf_pkg::OP_PUSH, WORD_MAX, 5'd0);
        add_req(rf_pkg::OP_PUSH, '1, 5'd0);
        add_req(rf_pkg::OP_PUSH, '0, 5'd0);
        add_req(rf_pkg::OP_PEEK_OLD, '0, 5'd0);
        add_req(rf_pkg::OP_PEEK_NEW, '0, 5'd0);
        add_req(rf_pkg::OP_SUM, '0, 5'd0);
        add_req(rf_pkg::OP_SUM, '0, 5'd4);
        add_req(rf_pkg::OP_SUM, '0, 5'd5);
        add_req(rf_pkg::OP_SUM, '0, 5'd31);
        add_req(OP_UNUSED_LO, '0, 5'd0);
        add_req(OP_UNUSED_HI, '0, 5'd0);
        add_req(rf_pkg::OP_POP, '0, 5'd0);

        // Single-slot ring: full on the second push
        write_depth(5'd1);
        add_req(rf_pkg::OP_PUSH, 32'h5555_5555, 5'd0);
        add_req(rf_pkg::OP_PUSH, 32'hAAAA_AAAA, 5'd0);
        add_req(rf_pkg::OP_PEEK_NEW, '0, 5'd0);
        add_req(rf_pkg::OP_SUM, '0, 5'd1);
        add_req(rf_pkg::OP_POP, '0, 5'd0);
        add_req(rf_pkg::OP_POP, '0, 5'd0);

        // Random phases over several depths, one without gaps
        for (p = 0; p < 10; p++) begin
            write_depth(p == 7 ? 5'($urandom_range(16, 1)) : phase_depth[p]);
            burst_mode = (p == 8);
            queue_random(150, (p % 3 == 0) ? 60 : (p % 3 == 1) ? 50 : 42);
        end

        // Drain, then allow for stray results
        while (results_checked != requests_issued) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/rf_pkg.sv
hw/rtl/rf_front.sv
hw/rtl/rf_back.sv
hw/rtl/ring_fifo_with_newest_sum.sv
tb/ring_fifo_with_newest_sum_tb.sv
